// ----- rtl/core/fbo_pkg.sv -----
// shared constants, types and tables for the four-bar output angle block
package fbo_pkg;

    localparam int ANGLE_FRACTION_BITS_DEF = 13;
    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int FIELD_W = 16;
    localparam int LEN_W = 16;
    localparam int INDEX_W = 2;

    localparam longint PI_Q30 = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint DELTA_Q30 = 64'sd16866297;
    localparam longint KINV_Q30 = 64'sd652032874;

    typedef enum logic [INDEX_W-1:0] {
        REG_CRANK,
        REG_COUPLER,
        REG_ROCKER,
        REG_GROUND
    } reg_index_t;

    typedef struct packed {
        logic [LEN_W-1:0] crank;
        logic [LEN_W-1:0] coupler;
        logic [LEN_W-1:0] rocker;
        logic [LEN_W-1:0] ground;
    } link_cfg_t;

    // cycles from lane input register to lane result register
    function automatic int lane_latency(input int n);
        return 2 * n + 73;
    endfunction

    // atan(2^-i) in q30, truncated
    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] v;
        case (i)
            0: v = 32'd843314856;
            1: v = 32'd497837829;
            2: v = 32'd263043836;
            3: v = 32'd133525158;
            4: v = 32'd67021686;
            5: v = 32'd33543515;
            6: v = 32'd16775850;
            7: v = 32'd8388437;
            8: v = 32'd4194282;
            9: v = 32'd2097149;
            10: v = 32'd1048575;
            11: v = 32'd524287;
            12: v = 32'd262143;
            13: v = 32'd131071;
            14: v = 32'd65535;
            15: v = 32'd32767;
            16: v = 32'd16383;
            17: v = 32'd8191;
            18: v = 32'd4095;
            19: v = 32'd2047;
            20: v = 32'd1023;
            21: v = 32'd511;
            22: v = 32'd255;
            23: v = 32'd127;
            24: v = 32'd63;
            25: v = 32'd31;
            26: v = 32'd15;
            27: v = 32'd7;
            28: v = 32'd3;
            29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/fbo_delay.sv -----
// enable-gated shift line that aligns side data with the datapath
module fbo_delay #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] line_reg [0:D-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_reg[0] <= d;
            for (int k = 1; k < D; k++)
            begin
                line_reg[k] <= line_reg[k-1];
            end
        end
    end

    assign q = line_reg[D-1];

endmodule

// ----- rtl/core/fbo_sincos.sv -----
// pipelined rotation cordic giving q30 sine and cosine
module fbo_sincos #(
    parameter int N = 16,
    parameter int TW = 35
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [TW-1:0] t,
    output logic signed [32:0]   cos_q,
    output logic signed [32:0]   sin_q
);

    localparam int CW = 33;
    localparam logic signed [TW-1:0] PI_T = TW'(fbo_pkg::PI_Q30);
    localparam logic signed [TW-1:0] HALF_T = TW'(fbo_pkg::HALF_PI_Q30);
    localparam logic signed [CW-1:0] KINV = CW'(fbo_pkg::KINV_Q30);

    logic signed [CW-1:0] x_reg [0:N];
    logic signed [CW-1:0] y_reg [0:N];
    logic signed [TW-1:0] z_reg [0:N-1];
    logic                 flip_reg [0:N];
    logic signed [CW-1:0] cos_reg;
    logic signed [CW-1:0] sin_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= KINV;
            y_reg[0] <= '0;
            if (t > HALF_T)
            begin
                z_reg[0] <= t - PI_T;
                flip_reg[0] <= 1'b1;
            end
            else if (t < -HALF_T)
            begin
                z_reg[0] <= t + PI_T;
                flip_reg[0] <= 1'b1;
            end
            else
            begin
                z_reg[0] <= t;
                flip_reg[0] <= 1'b0;
            end
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_iter
        localparam logic signed [TW-1:0] ATN = TW'(fbo_pkg::atan_q30(i));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                flip_reg[i+1] <= flip_reg[i];
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                end
            end
        end
        if (i < N - 1)
        begin : g_ang
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    z_reg[i+1] <= (z_reg[i] >= 0) ? z_reg[i] - ATN : z_reg[i] + ATN;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= flip_reg[N] ? -x_reg[N] : x_reg[N];
            sin_reg <= flip_reg[N] ? -y_reg[N] : y_reg[N];
        end
    end

    assign cos_q = cos_reg;
    assign sin_q = sin_reg;

endmodule

// ----- rtl/core/fbo_atan2.sv -----
// pipelined vectoring cordic giving the q30 angle of (x, y)
module fbo_atan2 #(
    parameter int N = 16,
    parameter int AW = 34
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [AW-1:0] x,
    input  logic signed [AW-1:0] y,
    output logic signed [33:0]   ang
);

    localparam int CW = 33;
    localparam int ZW = 34;
    localparam int PRE = AW - 30;
    localparam logic signed [AW-1:0] LIM = AW'(64'sd536870912);
    localparam logic signed [ZW-1:0] HALF_Z = ZW'(fbo_pkg::HALF_PI_Q30);

    logic signed [AW-1:0] xs;
    logic signed [AW-1:0] ys;
    logic signed [CW-1:0] x_reg [0:N-1];
    logic signed [CW-1:0] y_reg [0:N-1];
    logic signed [ZW-1:0] z_reg [0:N];
    logic                 zero_reg [0:N];

    // common right shift until both operands are below 2^29
    always_comb
    begin
        xs = x;
        ys = y;
        for (int k = 0; k < PRE; k++)
        begin
            if (xs >= LIM || xs <= -LIM || ys >= LIM || ys <= -LIM)
            begin
                xs = xs >>> 1;
                ys = ys >>> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (x == '0) && (y == '0);
            if (xs < 0)
            begin
                if (ys >= 0)
                begin
                    x_reg[0] <= CW'(ys);
                    y_reg[0] <= -CW'(xs);
                    z_reg[0] <= HALF_Z;
                end
                else
                begin
                    x_reg[0] <= -CW'(ys);
                    y_reg[0] <= CW'(xs);
                    z_reg[0] <= -HALF_Z;
                end
            end
            else
            begin
                x_reg[0] <= CW'(xs);
                y_reg[0] <= CW'(ys);
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_iter
        localparam logic signed [ZW-1:0] ATN = ZW'(fbo_pkg::atan_q30(i));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[i+1] <= zero_reg[i];
                z_reg[i+1] <= (y_reg[i] >= 0) ? z_reg[i] + ATN : z_reg[i] - ATN;
            end
        end
        if (i < N - 1)
        begin : g_vec
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (y_reg[i] >= 0)
                    begin
                        x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                        y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    end
                    else
                    begin
                        x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                        y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    end
                end
            end
        end
    end

    assign ang = zero_reg[N] ? '0 : z_reg[N];

endmodule

// ----- rtl/core/fbo_isqrt.sv -----
// pipelined integer square root, one result bit per stage
module fbo_isqrt #(
    parameter int W = 64
) (
    input  logic             clk,
    input  logic             en,
    input  logic [W-1:0]     rad,
    output logic [W/2-1:0]   root
);

    localparam int H = W / 2;

    logic [H+1:0] rem_reg  [1:H-1];
    logic [H-1:0] root_reg [1:H];
    logic [W-1:0] rad_reg  [1:H-1];

    for (genvar k = 0; k < H; k++)
    begin : g_step
        logic [H+1:0] rem_p;
        logic [H-1:0] root_p;
        logic [W-1:0] rad_p;
        logic [H+3:0] cur;
        logic [H+3:0] trial;
        logic [H+3:0] dif;
        logic         ge;

        if (k == 0)
        begin : g_head
            assign rem_p = '0;
            assign root_p = '0;
            assign rad_p = rad;
        end
        else
        begin : g_tail
            assign rem_p = rem_reg[k];
            assign root_p = root_reg[k];
            assign rad_p = rad_reg[k];
        end

        assign cur = {rem_p, rad_p[W-1 -: 2]};
        assign trial = (H+4)'({root_p, 2'b01});
        assign ge = cur >= trial;
        assign dif = cur - trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[k+1] <= {root_p[H-2:0], ge};
            end
        end

        if (k < H - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1] <= ge ? dif[H+1:0] : cur[H+1:0];
                    rad_reg[k+1] <= {rad_p[W-3:0], 2'b00};
                end
            end
        end
    end

    assign root = root_reg[H];

endmodule

// ----- rtl/core/fbo_lane.sv -----
// one linkage evaluation: diagonal, triangle terms and output angle
module fbo_lane #(
    parameter int N = 16,
    parameter int TW = 35
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [TW-1:0]     t,
    input  fbo_pkg::link_cfg_t       cfg,
    output logic signed [TW+1:0]     g,
    output logic                     bad
);

    localparam int GW = TW + 2;
    localparam int LS = N + 2;
    localparam int LA = N + 1;
    localparam int T_DLY = LS + 69 + LA;
    localparam int Z_DLY = 67 + LA;
    localparam int K_DLY = 66;
    localparam int N_DLY = 35;
    localparam int B_DLY = 34 + LA;
    localparam logic signed [33:0] PI_A = 34'(fbo_pkg::PI_Q30);

    logic signed [32:0] cos_w;
    logic signed [32:0] sin_w;
    logic signed [49:0] pc_reg;
    logic signed [49:0] ps_reg;
    logic signed [49:0] pcs;
    logic signed [49:0] pss;
    logic signed [28:0] x_reg;
    logic signed [28:0] y_reg;
    logic signed [57:0] xsq;
    logic signed [57:0] ysq;
    logic [53:0]        xx_reg;
    logic [53:0]        yy_reg;
    logic signed [28:0] ax_reg;
    logic signed [28:0] ym_reg;
    logic [53:0]        s_reg;
    logic signed [33:0] kap_w;
    logic [26:0]        e_w;
    logic [26:0]        orv;
    logic [4:0]         msb;
    logic [4:0]         sh;
    logic [26:0]        cq;
    logic [26:0]        dq;
    logic [14:0]        es_reg;
    logic [14:0]        cs_reg;
    logic [14:0]        ds_reg;
    logic [29:0]        es2_reg;
    logic [29:0]        ds2_reg;
    logic [29:0]        cs2_reg;
    logic [15:0]        sum_reg;
    logic signed [15:0] dif_reg;
    logic               dz_reg;
    logic signed [32:0] n_reg;
    logic [31:0]        psq_reg;
    logic signed [31:0] qsq_w;
    logic [29:0]        qsq_reg;
    logic [29:0]        cs2d_reg;
    logic               dz2_reg;
    logic signed [33:0] pa_reg;
    logic signed [31:0] pb_reg;
    logic               bad_reg;
    logic               npos_reg;
    logic [46:0]        lo_reg;
    logic [46:0]        hi_reg;
    logic [63:0]        prod_reg;
    logic [31:0]        root_w;
    logic signed [33:0] iota_w;
    logic [TW-1:0]      t_d;
    logic               zero_w;
    logic               zero_d;
    logic [33:0]        kap_d;
    logic [32:0]        n_d;
    logic [1:0]         flags_d;
    logic signed [33:0] iota_sel;
    logic signed [GW-1:0] g_reg;
    logic               bad_out_reg;

    fbo_sincos #(.N(N), .TW(TW)) u_sincos (
        .clk   (clk),
        .en    (en),
        .t     (t),
        .cos_q (cos_w),
        .sin_q (sin_w)
    );

    assign pcs = pc_reg >>> 22;
    assign pss = ps_reg >>> 22;
    assign xsq = x_reg * x_reg;
    assign ysq = y_reg * y_reg;
    assign zero_w = (x_reg == '0) && (y_reg == '0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pc_reg <= $signed({1'b0, cfg.coupler}) * cos_w;
            ps_reg <= $signed({1'b0, cfg.coupler}) * sin_w;
            x_reg <= $signed({5'b0, cfg.crank, 8'b0}) - $signed(pcs[28:0]);
            y_reg <= $signed(pss[28:0]);
            xx_reg <= xsq[53:0];
            yy_reg <= ysq[53:0];
            ax_reg <= (x_reg < 0) ? -x_reg : x_reg;
            ym_reg <= y_reg;
            s_reg <= xx_reg + yy_reg;
        end
    end

    fbo_atan2 #(.N(N), .AW(34)) u_kap (
        .clk (clk),
        .en  (en),
        .x   (34'(ax_reg)),
        .y   (34'(ym_reg)),
        .ang (kap_w)
    );

    fbo_isqrt #(.W(54)) u_diag (
        .clk  (clk),
        .en   (en),
        .rad  (s_reg),
        .root (e_w)
    );

    // common scale so the largest of e, c, d sits below 2^15
    assign cq = {3'b0, cfg.rocker, 8'b0};
    assign dq = {3'b0, cfg.ground, 8'b0};
    assign orv = e_w | cq | dq;

    always_comb
    begin
        msb = '0;
        for (int j = 0; j < 27; j++)
        begin
            if (orv[j])
            begin
                msb = 5'(j);
            end
        end
        sh = (msb >= 5'd15) ? msb - 5'd14 : '0;
    end

    assign qsq_w = dif_reg * dif_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            es_reg <= 15'(e_w >> sh);
            cs_reg <= 15'(cq >> sh);
            ds_reg <= 15'(dq >> sh);
            es2_reg <= es_reg * es_reg;
            ds2_reg <= ds_reg * ds_reg;
            cs2_reg <= cs_reg * cs_reg;
            sum_reg <= {1'b0, es_reg} + {1'b0, ds_reg};
            dif_reg <= $signed({1'b0, es_reg}) - $signed({1'b0, ds_reg});
            dz_reg <= (es_reg == '0) || (ds_reg == '0);
            n_reg <= $signed({3'b0, es2_reg}) + $signed({3'b0, ds2_reg})
                     - $signed({3'b0, cs2_reg});
            psq_reg <= sum_reg * sum_reg;
            qsq_reg <= qsq_w[29:0];
            cs2d_reg <= cs2_reg;
            dz2_reg <= dz_reg;
            pa_reg <= $signed({2'b0, psq_reg}) - $signed({4'b0, cs2d_reg});
            pb_reg <= $signed({2'b0, cs2d_reg}) - $signed({2'b0, qsq_reg});
            npos_reg <= !n_reg[32];
            bad_reg <= ($signed({2'b0, psq_reg}) < $signed({4'b0, cs2d_reg}))
                       || (cs2d_reg < qsq_reg) || dz2_reg;
            lo_reg <= pa_reg[15:0] * pb_reg[30:0];
            hi_reg <= pa_reg[31:16] * pb_reg[30:0];
            prod_reg <= {17'b0, lo_reg} + {1'b0, hi_reg, 16'b0};
        end
    end

    fbo_isqrt #(.W(64)) u_tri (
        .clk  (clk),
        .en   (en),
        .rad  (prod_reg),
        .root (root_w)
    );

    fbo_delay #(.W(33), .D(N_DLY)) u_n_dly (
        .clk (clk),
        .en  (en),
        .d   (n_reg),
        .q   (n_d)
    );

    fbo_atan2 #(.N(N), .AW(34)) u_iota (
        .clk (clk),
        .en  (en),
        .x   (34'($signed(n_d))),
        .y   ({2'b0, root_w}),
        .ang (iota_w)
    );

    fbo_delay #(.W(TW), .D(T_DLY)) u_t_dly (
        .clk (clk),
        .en  (en),
        .d   (t),
        .q   (t_d)
    );

    fbo_delay #(.W(1), .D(Z_DLY)) u_z_dly (
        .clk (clk),
        .en  (en),
        .d   (zero_w),
        .q   (zero_d)
    );

    fbo_delay #(.W(34), .D(K_DLY)) u_k_dly (
        .clk (clk),
        .en  (en),
        .d   (kap_w),
        .q   (kap_d)
    );

    fbo_delay #(.W(2), .D(B_DLY)) u_b_dly (
        .clk (clk),
        .en  (en),
        .d   ({bad_reg, npos_reg}),
        .q   (flags_d)
    );

    // linkage cannot close: acos term pinned to 0 or pi
    assign iota_sel = flags_d[1] ? (flags_d[0] ? '0 : PI_A) : iota_w;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (zero_d)
            begin
                g_reg <= GW'($signed(t_d));
            end
            else
            begin
                g_reg <= GW'($signed(kap_d)) - GW'(iota_sel);
            end
            bad_out_reg <= flags_d[1] && !zero_d;
        end
    end

    assign g = g_reg;
    assign bad = bad_out_reg;

endmodule

// ----- rtl/core/four_bar_output_angle.sv -----
// top level of the four-bar linkage output angle pipeline
//
// usage:
//   input channel: crank_angle (signed, radians) with in_valid / in_stall;
//   a beat is taken on a rising edge with in_valid high and in_stall low.
//   output channel: output_angle, angle_step and cannot_close with
//   out_valid / out_stall; one result beat per input beat, in order.
//   link lengths are written through cfg_write / cfg_index / cfg_data
//   while the pipeline is empty; all four reset to 1.0 (256).
//   pipeline depth is set by the two cordic passes and the two
//   square roots of each lane; the lanes for theta and theta+delta run
//   side by side.
//   throughput: one beat per cycle while out_stall does not hold a waiting result.
//   when out_stall holds a waiting result the whole pipeline freezes and
//   in_stall rises in the same cycle; nothing is dropped or repeated.
//   reset clears every valid bit, out_valid included, and restores the
//   link lengths; the result data registers are not reset.
module four_bar_output_angle #(
    parameter int ANGLE_FRACTION_BITS = fbo_pkg::ANGLE_FRACTION_BITS_DEF,
    parameter int CORDIC_ITERATIONS = fbo_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [fbo_pkg::FIELD_W-1:0] crank_angle,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [fbo_pkg::FIELD_W-1:0] output_angle,
    output logic signed [fbo_pkg::FIELD_W-1:0] angle_step,
    output logic                              cannot_close,
    input  logic                              cfg_write,
    input  logic [fbo_pkg::INDEX_W-1:0]       cfg_index,
    input  logic [fbo_pkg::LEN_W-1:0]         cfg_data
);

    localparam int N = CORDIC_ITERATIONS;
    localparam int FSH = 30 - ANGLE_FRACTION_BITS;
    localparam int TW = ((fbo_pkg::FIELD_W + FSH > 33) ? fbo_pkg::FIELD_W + FSH : 33) + 2;
    localparam int GW = TW + 2;
    localparam int DW = GW + 2;
    localparam int L = fbo_pkg::lane_latency(N);
    localparam logic signed [TW-1:0] DELTA_T = TW'(fbo_pkg::DELTA_Q30);
    localparam logic signed [DW-1:0] PI_D = DW'(fbo_pkg::PI_Q30);
    localparam logic signed [DW-1:0] TWO_PI_D = DW'(fbo_pkg::PI_Q30 * 2);
    localparam logic signed [DW:0] RND = (DW+1)'(64'sd1 <<< (FSH - 1));
    localparam logic signed [DW:0] SAT_MAX = (DW+1)'(32767);
    localparam logic signed [DW:0] SAT_MIN = -(DW+1)'(32768);

    fbo_pkg::link_cfg_t cfg_reg;
    logic               en;
    logic               v0_reg;
    logic [L:0]         vpipe_reg;
    logic signed [TW-1:0] ext;
    logic signed [TW-1:0] t0_reg;
    logic signed [TW-1:0] t1_reg;
    logic signed [GW-1:0] g0_w;
    logic signed [GW-1:0] g1_w;
    logic               bad0_w;
    logic               bad1_w;
    logic signed [DW-1:0] diff_w;
    logic signed [DW-1:0] step_reg;
    logic signed [DW-1:0] g0_reg;
    logic               bad_reg;
    logic               out_valid_reg;
    logic signed [fbo_pkg::FIELD_W-1:0] angle_reg;
    logic signed [fbo_pkg::FIELD_W-1:0] step_out_reg;
    logic               close_reg;

    function automatic logic signed [fbo_pkg::FIELD_W-1:0] to_field(
        input logic signed [DW-1:0] q
    );
        logic signed [DW:0] r;
        r = (DW+1)'(q) + RND;
        r = r >>> FSH;
        if (r > SAT_MAX)
        begin
            r = SAT_MAX;
        end
        else if (r < SAT_MIN)
        begin
            r = SAT_MIN;
        end
        return r[fbo_pkg::FIELD_W-1:0];
    endfunction

    assign en = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.crank <= 16'd256;
            cfg_reg.coupler <= 16'd256;
            cfg_reg.rocker <= 16'd256;
            cfg_reg.ground <= 16'd256;
        end
        else if (cfg_write)
        begin
            unique case (fbo_pkg::reg_index_t'(cfg_index))
                fbo_pkg::REG_CRANK:   cfg_reg.crank <= cfg_data;
                fbo_pkg::REG_COUPLER: cfg_reg.coupler <= cfg_data;
                fbo_pkg::REG_ROCKER:  cfg_reg.rocker <= cfg_data;
                fbo_pkg::REG_GROUND:  cfg_reg.ground <= cfg_data;
                default: ;
            endcase
        end
    end

    assign ext = TW'(crank_angle) <<< FSH;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t0_reg <= ext;
            t1_reg <= ext + DELTA_T;
        end
    end

    fbo_lane #(.N(N), .TW(TW)) u_lane0 (
        .clk (clk),
        .en  (en),
        .t   (t0_reg),
        .cfg (cfg_reg),
        .g   (g0_w),
        .bad (bad0_w)
    );

    fbo_lane #(.N(N), .TW(TW)) u_lane1 (
        .clk (clk),
        .en  (en),
        .t   (t1_reg),
        .cfg (cfg_reg),
        .g   (g1_w),
        .bad (bad1_w)
    );

    assign diff_w = DW'(g1_w) - DW'(g0_w);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            step_reg <= (diff_w < -PI_D) ? diff_w + TWO_PI_D : diff_w;
            g0_reg <= DW'(g0_w);
            bad_reg <= bad0_w || bad1_w;
            angle_reg <= to_field(g0_reg);
            step_out_reg <= to_field(step_reg);
            close_reg <= bad_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            vpipe_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            vpipe_reg <= {vpipe_reg[L-1:0], v0_reg};
            out_valid_reg <= vpipe_reg[L];
        end
    end

    assign out_valid = out_valid_reg;
    assign output_angle = angle_reg;
    assign angle_step = step_out_reg;
    assign cannot_close = close_reg;

endmodule

// ----- rtl/core/fbo_check.sv -----
// port-level assertions for the four-bar output angle block
module fbo_check (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic signed [fbo_pkg::FIELD_W-1:0] output_angle,
    input logic signed [fbo_pkg::FIELD_W-1:0] angle_step
);

    // input only backs up behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("in_stall without a held result");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("out_valid during reset");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(output_angle) && $stable(angle_step)))
        else $error("result changed while stalled");

endmodule

bind four_bar_output_angle fbo_check u_fbo_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .output_angle (output_angle),
    .angle_step   (angle_step)
);

// ----- test/four_bar_output_angle_tb.sv -----
// testbench for the four-bar linkage output angle pipeline, checked against a built-in predictor
module four_bar_output_angle_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = fbo_pkg::ANGLE_FRACTION_BITS_DEF;
    localparam int ITERS = fbo_pkg::CORDIC_ITERATIONS_DEF;
    localparam int LATENCY = 2 * ITERS + 76;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic signed [fbo_pkg::FIELD_W-1:0] angle;
        logic signed [fbo_pkg::FIELD_W-1:0] step;
        logic                               bad;
    } linkage_result_t;

    typedef struct {
        logic [fbo_pkg::LEN_W-1:0]          a, b, c, d;
        logic signed [fbo_pkg::FIELD_W-1:0] theta;
        bit                                 typed;
        linkage_result_t                    res;
    } stim_row_t;

    localparam longint ATAN_TAB [0:31] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
        131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
        127, 63, 31, 15, 7, 3, 1, 0, 0};

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [fbo_pkg::FIELD_W-1:0] crank_angle;
    logic out_valid;
    logic out_stall;
    logic signed [fbo_pkg::FIELD_W-1:0] output_angle;
    logic signed [fbo_pkg::FIELD_W-1:0] angle_step;
    logic cannot_close;
    logic cfg_write;
    fbo_pkg::reg_index_t cfg_index;
    logic [fbo_pkg::LEN_W-1:0] cfg_data;

    four_bar_output_angle dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .crank_angle(crank_angle),
        .out_valid(out_valid), .out_stall(out_stall),
        .output_angle(output_angle), .angle_step(angle_step),
        .cannot_close(cannot_close),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    longint link_a, link_b, link_c, link_d;
    linkage_result_t pending_q[$];
    stim_row_t rows[$];
    int errors;
    int cycles;
    int burst_left;
    bit hold_req;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= r + bitv)
            begin
                v -= r + bitv;
                r = (r >> 1) + bitv;
            end
            else
                r >>= 1;
            bitv >>= 2;
        end
        return r;
    endfunction

    function automatic longint absval(input longint v);
        return v < 0 ? -v : v;
    endfunction

    task automatic rotate_sincos(input longint t, output longint s, output longint co);
        bit flip;
        longint x, y, nx;
        flip = 0;
        x = fbo_pkg::KINV_Q30;
        y = 0;
        if (t > fbo_pkg::HALF_PI_Q30)
        begin
            t -= fbo_pkg::PI_Q30;
            flip = 1;
        end
        else if (t < -fbo_pkg::HALF_PI_Q30)
        begin
            t += fbo_pkg::PI_Q30;
            flip = 1;
        end
        for (int i = 0; i < ITERS && i < 32; i++)
        begin
            if (t >= 0)
            begin
                nx = x - (y >>> i); y = y + (x >>> i); t -= ATAN_TAB[i];
            end
            else
            begin
                nx = x + (y >>> i); y = y - (x >>> i); t += ATAN_TAB[i];
            end
            x = nx;
        end
        co = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint vector_atan2(input longint y, input longint x);
        longint z, nx, t;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        while (absval(x) >= (64'sd1 << 29) || absval(y) >= (64'sd1 << 29))
        begin
            x = x >>> 1;
            y = y >>> 1;
        end
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; z = fbo_pkg::HALF_PI_Q30;
            end
            else
            begin
                t = x; x = -y; y = t; z = -fbo_pkg::HALF_PI_Q30;
            end
        end
        for (int i = 0; i < ITERS && i < 32; i++)
        begin
            if (y >= 0)
            begin
                nx = x + (y >>> i); y = y - (x >>> i); z += ATAN_TAB[i];
            end
            else
            begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= ATAN_TAB[i];
            end
            x = nx;
        end
        return z;
    endfunction

    task automatic output_angle_q30(input longint t, inout bit bad, output longint g);
        longint s, co, x, y, e, cq, dq, m, n, dd, pa, pb, iota, kap;
        int sh;
        sh = 0;
        rotate_sincos(t, s, co);
        x = link_a * 256 - ((link_b * co) >>> 22);
        y = (link_b * s) >>> 22;
        if (x == 0 && y == 0)
        begin
            g = t;
            return;
        end
        kap = vector_atan2(y, absval(x));
        e = longint'(int_sqrt(longint'(x * x + y * y)));
        cq = link_c * 256;
        dq = link_d * 256;
        m = e;
        if (cq > m) m = cq;
        if (dq > m) m = dq;
        while ((m >> sh) >= 32768)
            sh++;
        e = e >> sh;
        cq = cq >> sh;
        dq = dq >> sh;
        n = e * e + dq * dq - cq * cq;
        dd = 2 * e * dq;
        pa = (e + dq) * (e + dq) - cq * cq;
        pb = cq * cq - (e - dq) * (e - dq);
        if (pa < 0 || pb < 0 || dd == 0)
        begin
            bad = 1;
            iota = n >= 0 ? 0 : fbo_pkg::PI_Q30;
        end
        else
            iota = vector_atan2(longint'(int_sqrt(longint'(pa) * longint'(pb))), n);
        g = kap - iota;
    endtask

    function automatic logic signed [fbo_pkg::FIELD_W-1:0] round_sat(input longint q30);
        longint v;
        v = (q30 + (64'sd1 << (29 - FRAC))) >>> (30 - FRAC);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[fbo_pkg::FIELD_W-1:0];
    endfunction

    task automatic predict_linkage(input logic signed [fbo_pkg::FIELD_W-1:0] theta,
                                   output linkage_result_t r);
        bit bad;
        longint t, g0, g1, diff;
        bad = 0;
        t = longint'(theta) * (64'sd1 << (30 - FRAC));
        output_angle_q30(t, bad, g0);
        output_angle_q30(t + fbo_pkg::DELTA_Q30, bad, g1);
        diff = g1 - g0;
        if (diff < -fbo_pkg::PI_Q30)
            diff += 2 * fbo_pkg::PI_Q30;
        r.angle = round_sat(g0);
        r.step = round_sat(diff);
        r.bad = bad;
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL four_bar_output_angle");
            $finish;
        end
    end

    // result beat checker
    always @(posedge clk)
    begin
        linkage_result_t ex;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat angle=%0d step=%0d flag=%0d",
                         $time, output_angle, angle_step, cannot_close);
            end
            else
            begin
                ex = pending_q.pop_front();
                if (output_angle !== ex.angle)
                begin
                    errors++;
                    $display("%0t: output_angle expected %0d actual %0d",
                             $time, ex.angle, output_angle);
                end
                if (angle_step !== ex.step)
                begin
                    errors++;
                    $display("%0t: angle_step expected %0d actual %0d",
                             $time, ex.step, angle_step);
                end
                if (cannot_close !== ex.bad)
                begin
                    errors++;
                    $display("%0t: cannot_close expected %0d actual %0d",
                             $time, ex.bad, cannot_close);
                end
            end
        end
    end

    // receiver stall pattern, with a long hold on request
    initial
    begin
        int mode;
        int left;
        int held;
        out_stall = 1'b0;
        mode = 0;
        left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                for (held = 1; held < HOLD_CYCLES; held++)
                    @(negedge clk);
                hold_req = 0;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(16, 96);
                end
                left--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= left[0];
                    default: out_stall <= ($urandom_range(0, 1) == 0);
                endcase
            end
        end
    end

    task automatic drain_results();
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_links(input logic [fbo_pkg::LEN_W-1:0] a, b, c, d);
        drain_results();
        cfg_write <= 1'b1; cfg_index <= fbo_pkg::REG_CRANK; cfg_data <= a;
        @(negedge clk);
        cfg_index <= fbo_pkg::REG_COUPLER; cfg_data <= b;
        @(negedge clk);
        cfg_index <= fbo_pkg::REG_ROCKER; cfg_data <= c;
        @(negedge clk);
        cfg_index <= fbo_pkg::REG_GROUND; cfg_data <= d;
        @(negedge clk);
        cfg_write <= 1'b0;
        link_a = a; link_b = b; link_c = c; link_d = d;
    endtask

    // offer one input beat; bursts with random gaps between them
    task automatic send_angle(input logic signed [fbo_pkg::FIELD_W-1:0] theta,
                              input bit typed, input linkage_result_t typed_res);
        linkage_result_t r;
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        crank_angle <= theta;
        do
            @(posedge clk);
        while (in_stall);
        if (typed)
            r = typed_res;
        else
            predict_linkage(theta, r);
        pending_q.push_back(r);
        burst_left--;
        @(negedge clk);
    endtask

    task automatic add_row(input logic [fbo_pkg::LEN_W-1:0] a, b, c, d,
                           input logic signed [fbo_pkg::FIELD_W-1:0] theta, input bit typed,
                           input logic signed [fbo_pkg::FIELD_W-1:0] ang, stp,
                           input logic bad);
        stim_row_t row;
        row.a = a; row.b = b; row.c = c; row.d = d;
        row.theta = theta;
        row.typed = typed;
        row.res.angle = ang; row.res.step = stp; row.res.bad = bad;
        rows.push_back(row);
    endtask

    function automatic logic signed [fbo_pkg::FIELD_W-1:0] random_angle();
        logic signed [fbo_pkg::FIELD_W-1:0] v;
        case ($urandom_range(0, 7))
            0: v = 16'sd25736 + $signed(16'($urandom_range(0, 64))) - 16'sd32;
            1: v = -16'sd25736 + $signed(16'($urandom_range(0, 64))) - 16'sd32;
            2: v = 16'sd12868 + $signed(16'($urandom_range(0, 64))) - 16'sd32;
            default: v = 16'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    initial
    begin
        linkage_result_t none;
        logic [fbo_pkg::LEN_W-1:0] a, b, c, d;
        errors = 0;
        cycles = 0;
        burst_left = 0;
        hold_req = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        crank_angle = '0;
        cfg_write = 1'b0;
        cfg_index = fbo_pkg::REG_CRANK;
        cfg_data = '0;
        link_a = 256; link_b = 256; link_c = 256; link_d = 256;
        none = '{default: 0};

        // reset lengths; angles near zero, pi/2, pi and the field extremes
        add_row(256, 256, 256, 256, 0, 0, 0, 0, 0);
        add_row(256, 256, 256, 256, 16'sd32767, 0, 0, 0, 0);
        add_row(256, 256, 256, 256, -16'sd32768, 0, 0, 0, 0);
        add_row(256, 256, 256, 256, 16'sd12868, 0, 0, 0, 0);
        add_row(256, 256, 256, 256, -16'sd12868, 0, 0, 0, 0);
        add_row(256, 256, 256, 256, 16'sd25736, 0, 0, 0, 0);
        add_row(256, 256, 256, 256, -16'sd25736, 0, 0, 0, 0);
        // zero diagonal: the angle passes through, step is delta
        add_row(0, 0, 256, 256, 0, 1, 0, 129, 0);
        add_row(0, 0, 256, 256, 16'sd32767, 1, 16'sd32767, 129, 0);
        add_row(0, 0, 256, 256, -16'sd32768, 1, -16'sd32768, 129, 0);
        add_row(0, 0, 256, 256, 16'sd1000, 1, 16'sd1000, 129, 0);
        // ground zero: linkage cannot close
        add_row(256, 256, 256, 0, 16'sd3000, 0, 0, 0, 0);
        add_row(256, 256, 256, 0, -16'sd3000, 0, 0, 0, 0);
        // triangle fails on the long diagonal
        add_row(1024, 256, 256, 256, 0, 0, 0, 0, 0);
        add_row(1024, 256, 256, 256, 16'sd20000, 0, 0, 0, 0);
        // longest lengths and a typical linkage
        add_row(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'sd5000, 0, 0, 0, 0);
        add_row(16'hffff, 16'hffff, 16'hffff, 16'hffff, -16'sd32768, 0, 0, 0, 0);
        add_row(128, 512, 640, 768, 16'sd6000, 0, 0, 0, 0);
        add_row(128, 512, 640, 768, -16'sd20000, 0, 0, 0, 0);
        add_row(0, 0, 0, 0, 16'sd7, 1, 16'sd7, 129, 0);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            if (rows[i].a != link_a || rows[i].b != link_b ||
                rows[i].c != link_c || rows[i].d != link_d)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
                write_links(rows[i].a, rows[i].b, rows[i].c, rows[i].d);
            end
            send_angle(rows[i].theta, rows[i].typed, rows[i].res);
        end

        for (int phase = 0; phase < 6; phase++)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            if (phase == 0 || phase == 5)
            begin
                a = 16'($urandom_range(0, 65535)); b = 16'($urandom_range(0, 65535));
                c = 16'($urandom_range(0, 65535)); d = 16'($urandom_range(0, 65535));
            end
            else
            begin
                a = 16'($urandom_range(64, 512)); b = 16'($urandom_range(256, 1024));
                c = 16'($urandom_range(256, 1024)); d = 16'($urandom_range(256, 1024));
            end
            write_links(a, b, c, d);
            if (phase == 2)
                hold_req = 1;
            for (int k = 0; k < 125; k++)
            begin
                if (phase == 3 && k == 60)
                begin
                    in_valid <= 1'b0;
                    @(negedge clk);
                    while (pending_q.size() != 0)
                        @(negedge clk);
                end
                send_angle(random_angle(), 0, none);
            end
        end
        in_valid <= 1'b0;

        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        if (errors == 0)
            $display("PASS four_bar_output_angle");
        else
            $display("FAIL four_bar_output_angle");
        $finish;
    end
endmodule
